// ----- rtl/core/mpdt_pkg.sv -----
// mpdt_pkg: shared types and codes of the multimode delay timer
// timer phase encoding, mode codes, register indexes and the step flag struct
// no dependencies
`default_nettype none

package mpdt_pkg;

    // timer phase, also presented on the status output
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RUN   = 3'd1,
        PH_PAUSE = 3'd2,
        PH_READY = 3'd3,
        PH_OVF   = 3'd4
    } phase_t;

    // timer mode codes, codes above interval behave as on-delay
    localparam logic [2:0] MODE_ON_DELAY  = 3'd0;
    localparam logic [2:0] MODE_OFF_DELAY = 3'd1;
    localparam logic [2:0] MODE_PULSE     = 3'd2;
    localparam logic [2:0] MODE_RETENTIVE = 3'd3;
    localparam logic [2:0] MODE_INTERVAL  = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESET   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVF_LIMIT = 2'd2;

    // register reset values
    localparam logic [2:0]  MODE_RESET      = MODE_ON_DELAY;
    localparam logic [31:0] PRESET_RESET    = 32'd1000;
    localparam logic [31:0] OVF_LIMIT_RESET = 32'd2147483647;

    // request kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // flags produced by one timer step
    typedef struct packed {
        logic   q;
        phase_t phase;
    } step_flags_t;

endpackage : mpdt_pkg

`default_nettype wire

// ----- rtl/core/multimode_plc_delay_timer_core.sv -----
// multimode_plc_delay_timer_core: top level of the multimode delay timer
// request and result registers, configuration registers and timer state
// depends on mpdt_pkg and mpdt_step
//
// Usage
//   Requests enter on the s_ channel (valid/ready): s_kind selects a trigger
//   sample or a clear, s_now_ms is the millisecond time, s_trigger the level.
//   Each request gives one result on the m_ channel: q_out, elapsed_ms and
//   timer_status. Registers are written over the cfg_ channel by index
//   (0 timer mode, 1 preset, 2 overflow limit, 3 ignored); cfg_ready is
//   always high. A mode write returns the timer to idle, or ready in
//   off-delay mode.
//   A request passes through one request register, then the step logic into
//   the result register and the timer state, before m_valid is raised.
//   Throughput is one request per cycle while m_ready is high, set by the
//   state update in the step logic. A stalled m_ready holds the result; the
//   request register still takes one more request before s_ready drops.
//   Reset (aresetn low, synchronous) empties both stages, sets the mode to
//   on-delay, preset 1000, limit 2147483647, and the timer idle.
`default_nettype none

module multimode_plc_delay_timer_core #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [31:0]                       s_now_ms,
    input  wire logic                              s_trigger,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_q_out,
    output logic [31:0]                            m_elapsed_ms,
    output logic [2:0]                             m_timer_status,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpdt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                       cfg_data
);

    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [31:0]           in_now_reg;
    logic                  in_trig_reg;
    logic                  out_valid_reg;
    logic                  out_q_reg;
    logic [31:0]           out_elapsed_reg;
    logic [2:0]            out_status_reg;
    logic [2:0]            mode_reg;
    logic [31:0]           preset_reg;
    logic [31:0]           limit_reg;
    mpdt_pkg::phase_t      phase_reg;
    logic [TIME_BITS-1:0]  ref_reg;

    mpdt_pkg::step_flags_t flags_next;
    logic [TIME_BITS-1:0]  ref_next;
    logic [31:0]           elapsed_next;
    logic                  out_free;
    logic                  advance;
    logic                  cfg_write;

    // handshake control
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // timer step for the request held in the request register
    mpdt_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .timer_mode     (mode_reg),
        .preset_ms      (preset_reg),
        .overflow_limit (limit_reg),
        .phase_cur      (phase_reg),
        .ref_cur        (ref_reg),
        .kind           (in_kind_reg),
        .now_ms         (in_now_reg),
        .trigger        (in_trig_reg),
        .flags_next     (flags_next),
        .ref_next       (ref_next),
        .elapsed_ms     (elapsed_next)
    );

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_now_reg  <= s_now_ms;
            in_trig_reg <= s_trigger;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_q_reg       <= flags_next.q;
            out_elapsed_reg <= elapsed_next;
            out_status_reg  <= 3'(flags_next.phase);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= mpdt_pkg::MODE_RESET;
            preset_reg <= mpdt_pkg::PRESET_RESET;
            limit_reg  <= mpdt_pkg::OVF_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                mpdt_pkg::CFG_MODE:      mode_reg   <= cfg_data[2:0];
                mpdt_pkg::CFG_PRESET:    preset_reg <= cfg_data;
                mpdt_pkg::CFG_OVF_LIMIT: limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // timer state: a mode write reinitialises it, a request steps it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mpdt_pkg::PH_IDLE;
            ref_reg   <= '0;
        end else if (cfg_write && (cfg_index == mpdt_pkg::CFG_MODE)) begin
            phase_reg <= (cfg_data[2:0] == mpdt_pkg::MODE_OFF_DELAY) ?
                         mpdt_pkg::PH_READY : mpdt_pkg::PH_IDLE;
            ref_reg   <= '0;
        end else if (advance) begin
            phase_reg <= flags_next.phase;
            ref_reg   <= ref_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_q_out        = out_q_reg;
    assign m_elapsed_ms   = out_elapsed_reg;
    assign m_timer_status = out_status_reg;

endmodule : multimode_plc_delay_timer_core

`default_nettype wire

// ----- rtl/core/mpdt_step.sv -----
// mpdt_step: next-state and result logic for one timer request
// purely combinational, all candidate times are formed in parallel
// depends on mpdt_pkg
`default_nettype none

module mpdt_step #(
    parameter int TIME_BITS = 32
) (
    input  wire logic [2:0]           timer_mode,
    input  wire logic [31:0]          preset_ms,
    input  wire logic [31:0]          overflow_limit,
    input  mpdt_pkg::phase_t          phase_cur,
    input  wire logic [TIME_BITS-1:0] ref_cur,
    input  wire logic                 kind,
    input  wire logic [31:0]          now_ms,
    input  wire logic                 trigger,
    output mpdt_pkg::step_flags_t     flags_next,
    output logic [TIME_BITS-1:0]      ref_next,
    output logic [31:0]               elapsed_ms
);

    // compare width covers both the time word and the 32-bit registers
    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [CMP_W-1:0]     now_w;
    logic [CMP_W-1:0]     preset_w;
    logic [CMP_W-1:0]     limit_w;
    logic [CMP_W-1:0]     el_w;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] preset_t;
    logic [TIME_BITS-1:0] limit_t;
    logic [TIME_BITS-1:0] e_start;
    logic [TIME_BITS-1:0] e_minus;
    logic [TIME_BITS-1:0] ref_run;
    logic [TIME_BITS-1:0] ref_plus;
    logic [TIME_BITS-1:0] ref_cur_plus;
    logic [TIME_BITS-1:0] limit_plus;
    logic [TIME_BITS-1:0] el_t;
    logic                 can_run;
    logic                 ovf;
    logic                 hit;
    logic                 limit_hit;
    logic                 ref_hit;
    logic                 sub_preset;
    logic                 q;
    mpdt_pkg::phase_t     phase_n;
    logic [TIME_BITS-1:0] ref_n;

    // operands brought to the time width
    assign now_w    = CMP_W'(now_ms);
    assign preset_w = CMP_W'(preset_ms);
    assign limit_w  = CMP_W'(overflow_limit);
    assign now_t    = now_w[TIME_BITS-1:0];
    assign preset_t = preset_w[TIME_BITS-1:0];
    assign limit_t  = limit_w[TIME_BITS-1:0];

    // a start from idle or pause, or an already running timer, all run
    assign can_run = (phase_cur == mpdt_pkg::PH_IDLE) ||
                     (phase_cur == mpdt_pkg::PH_PAUSE) ||
                     (phase_cur == mpdt_pkg::PH_RUN);

    // elapsed time and start reference once running at this sample
    always_comb begin
        unique case (phase_cur)
            mpdt_pkg::PH_IDLE: begin
                e_start  = '0;
                ref_run  = now_t;
                e_minus  = {TIME_BITS{1'b0}} - preset_t;
                ref_plus = now_t + preset_t;
            end
            mpdt_pkg::PH_PAUSE: begin
                e_start  = ref_cur;
                ref_run  = now_t - ref_cur;
                e_minus  = ref_cur - preset_t;
                ref_plus = now_t - ref_cur + preset_t;
            end
            default: begin
                e_start  = now_t - ref_cur;
                ref_run  = ref_cur;
                e_minus  = now_t - ref_cur - preset_t;
                ref_plus = ref_cur + preset_t;
            end
        endcase
    end

    // threshold checks, all in parallel
    assign ovf          = CMP_W'(e_start) > limit_w;
    assign hit          = CMP_W'(e_start) >= preset_w;
    assign limit_hit    = CMP_W'(limit_t) >= preset_w;
    assign ref_hit      = CMP_W'(ref_cur) >= preset_w;
    assign ref_cur_plus = ref_cur + preset_t;
    assign limit_plus   = limit_t + preset_t;

    // mode behaviour
    always_comb begin
        phase_n    = phase_cur;
        ref_n      = ref_cur;
        q          = 1'b0;
        sub_preset = 1'b0;
        if (kind == mpdt_pkg::KIND_CLEAR) begin
            phase_n = mpdt_pkg::PH_IDLE;
            ref_n   = '0;
        end else begin
            case (timer_mode)
                mpdt_pkg::MODE_OFF_DELAY: begin
                    if (!trigger) begin
                        if (can_run) begin
                            if (ovf) begin
                                phase_n = mpdt_pkg::PH_OVF;
                                ref_n   = limit_t;
                            end else if (hit) begin
                                phase_n = mpdt_pkg::PH_READY;
                                ref_n   = e_start;
                            end else begin
                                phase_n = mpdt_pkg::PH_RUN;
                                ref_n   = ref_run;
                            end
                        end
                    end else begin
                        phase_n = mpdt_pkg::PH_IDLE;
                        ref_n   = '0;
                    end
                    q = trigger || (phase_n == mpdt_pkg::PH_RUN);
                end
                mpdt_pkg::MODE_PULSE: begin
                    if (trigger ? can_run : (phase_cur == mpdt_pkg::PH_RUN)) begin
                        if (ovf) begin
                            phase_n = mpdt_pkg::PH_OVF;
                            ref_n   = limit_t;
                        end else if (hit) begin
                            phase_n = mpdt_pkg::PH_READY;
                            ref_n   = e_start;
                        end else begin
                            phase_n = mpdt_pkg::PH_RUN;
                            ref_n   = ref_run;
                        end
                    end
                    // pulse finished and trigger released: back to idle
                    if (!trigger && (phase_n == mpdt_pkg::PH_READY)) begin
                        phase_n = mpdt_pkg::PH_IDLE;
                        ref_n   = '0;
                    end
                    q = (phase_n == mpdt_pkg::PH_RUN);
                end
                mpdt_pkg::MODE_RETENTIVE: begin
                    if (trigger) begin
                        if (can_run) begin
                            if (ovf) begin
                                phase_n = mpdt_pkg::PH_OVF;
                                ref_n   = limit_t;
                            end else if (hit) begin
                                phase_n = mpdt_pkg::PH_READY;
                                ref_n   = e_start;
                            end else begin
                                phase_n = mpdt_pkg::PH_RUN;
                                ref_n   = ref_run;
                            end
                        end
                    end else if (phase_cur == mpdt_pkg::PH_RUN) begin
                        // pause keeps the elapsed time
                        if (ovf) begin
                            phase_n = mpdt_pkg::PH_OVF;
                            ref_n   = limit_t;
                        end else begin
                            phase_n = mpdt_pkg::PH_PAUSE;
                            ref_n   = e_start;
                        end
                    end
                    q = (phase_n == mpdt_pkg::PH_READY);
                end
                mpdt_pkg::MODE_INTERVAL: begin
                    if (trigger) begin
                        if (can_run) begin
                            if (ovf) begin
                                // the latched limit still counts intervals
                                phase_n = mpdt_pkg::PH_OVF;
                                ref_n   = limit_hit ? limit_plus : limit_t;
                                q       = limit_hit;
                            end else begin
                                phase_n    = mpdt_pkg::PH_RUN;
                                ref_n      = hit ? ref_plus : ref_run;
                                q          = hit;
                                sub_preset = hit;
                            end
                        end else begin
                            ref_n = ref_hit ? ref_cur_plus : ref_cur;
                            q     = ref_hit;
                        end
                    end else begin
                        phase_n = mpdt_pkg::PH_IDLE;
                        ref_n   = '0;
                    end
                end
                default: begin
                    // on-delay, also for the unused mode codes
                    if (trigger) begin
                        if (can_run) begin
                            if (ovf) begin
                                phase_n = mpdt_pkg::PH_OVF;
                                ref_n   = limit_t;
                            end else if (hit) begin
                                phase_n = mpdt_pkg::PH_READY;
                                ref_n   = e_start;
                            end else begin
                                phase_n = mpdt_pkg::PH_RUN;
                                ref_n   = ref_run;
                            end
                        end
                    end else begin
                        phase_n = mpdt_pkg::PH_IDLE;
                        ref_n   = '0;
                    end
                    q = (phase_n == mpdt_pkg::PH_READY);
                end
            endcase
        end
    end

    // reading: running time, or the latched word in any other phase
    always_comb begin
        if (phase_n == mpdt_pkg::PH_RUN) begin
            el_t = sub_preset ? e_minus : e_start;
        end else begin
            el_t = ref_n;
        end
    end

    assign el_w             = CMP_W'(el_t);
    assign elapsed_ms       = el_w[31:0];
    assign ref_next         = ref_n;
    assign flags_next.q     = q;
    assign flags_next.phase = phase_n;

endmodule : mpdt_step

`default_nettype wire
